/* rtl/core/sit_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_pkg
// Shared sizes, codes and types of the string interning table.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int BLOCK_BYTES = 65536;
    localparam int STORE_BYTES = 262144;
    localparam int MAX_LENGTH  = 256;

    localparam int HASH_W   = 32;
    localparam int LEN_W    = $clog2(MAX_LENGTH + 1);
    localparam int PEND_AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int PROBE_W  = SLOT_W + 1;
    localparam int ENT_W    = SLOT_W + 1;
    localparam int HANDLE_W = $clog2(STORE_BYTES);
    localparam int CW       = 32;

    localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_STORE_FULL = 2'd3;

    // finished string waiting for the back end
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  len;
        logic              overlong;
    } fr_desc_t;

    // back end requests towards the front end
    typedef struct packed {
        logic               pop;
        logic               busy;
        logic [PEND_AW-1:0] pend_addr;
    } bk_ctl_t;

    typedef struct packed {
        logic                valid;
        logic [HASH_W-1:0]   hash;
        logic [HANDLE_W-1:0] handle;
    } slot_t;

endpackage

`default_nettype wire

/* rtl/core/sit_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_front
// Accepts string bytes, folds them into the FNV-1a hash, buffers them and
// queues the finished string for the back end.
// ----------------------------------------------------------------------------
module sit_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [7:0]                    char_byte,
    input  wire logic                          no_byte,
    input  wire logic                          last,
    input  wire sit_pkg::bk_ctl_t              ctl,
    output sit_pkg::fr_desc_t                  desc,
    output logic [7:0]                         pend_q
);

    logic [sit_pkg::HASH_W-1:0] running_hash_reg, running_hash_next;
    logic [sit_pkg::LEN_W-1:0]  pending_length_reg, pending_length_next;
    logic                       overlong_reg, overlong_next;
    sit_pkg::fr_desc_t          queue_reg, queue_next;
    logic [sit_pkg::HASH_W-1:0] hash_mix;
    logic                       accept;
    logic                       len_full;
    logic                       buf_we;

    logic [7:0] pend_mem [sit_pkg::MAX_LENGTH];

    assign busy     = queue_reg.valid || ctl.busy;
    assign accept   = start && !busy;
    assign len_full = (pending_length_reg == sit_pkg::LEN_W'(sit_pkg::MAX_LENGTH));
    assign hash_mix = (running_hash_reg ^ {24'd0, char_byte}) * sit_pkg::HASH_PRIME;
    assign buf_we   = accept && !no_byte && !len_full;
    assign desc     = queue_reg;

    always_comb
    begin
        running_hash_next   = running_hash_reg;
        pending_length_next = pending_length_reg;
        overlong_next       = overlong_reg;
        queue_next          = queue_reg;
        if (ctl.pop)
        begin
            queue_next.valid = 1'b0;
        end
        if (accept && !no_byte)
        begin
            running_hash_next = hash_mix;
            if (len_full)
                overlong_next = 1'b1;
            else
                pending_length_next = pending_length_reg + 1'b1;
        end
        if (accept && last)
        begin
            // hand the string over and start afresh
            queue_next.valid    = 1'b1;
            queue_next.hash     = running_hash_next;
            queue_next.len      = pending_length_next;
            queue_next.overlong = overlong_next;
            running_hash_next   = sit_pkg::HASH_BASIS;
            pending_length_next = '0;
            overlong_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg   <= sit_pkg::HASH_BASIS;
            pending_length_reg <= '0;
            overlong_reg       <= 1'b0;
            queue_reg          <= '0;
        end
        else
        begin
            running_hash_reg   <= running_hash_next;
            pending_length_reg <= pending_length_next;
            overlong_reg       <= overlong_next;
            queue_reg          <= queue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            pend_mem[pending_length_reg[sit_pkg::PEND_AW-1:0]] <= char_byte;
        pend_q <= pend_mem[ctl.pend_addr];
    end

    a_no_accept_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
        queue_reg.valid |-> !accept)
        else $error("front accepted a byte while a string was queued");

endmodule

`default_nettype wire

/* rtl/core/sit_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sit_back
// Probes the slot table, compares stored strings, copies new strings into
// the byte store and produces the result transaction.
// ----------------------------------------------------------------------------
module sit_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sit_pkg::fr_desc_t             desc,
    input  wire logic [7:0]                    pend_q,
    output sit_pkg::bk_ctl_t                   ctl,
    output logic                               done,
    output logic [sit_pkg::HANDLE_W-1:0]       handle,
    output logic                               was_present,
    output logic [1:0]                         status,
    output logic [sit_pkg::HASH_W-1:0]         hash_value,
    output logic [sit_pkg::LEN_W-1:0]          length
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_SLOT_RD  = 4'd2;
    localparam logic [3:0] S_SLOT_CHK = 4'd3;
    localparam logic [3:0] S_CMP_RD   = 4'd4;
    localparam logic [3:0] S_CMP_CHK  = 4'd5;
    localparam logic [3:0] S_PLACE    = 4'd6;
    localparam logic [3:0] S_COPY_RD  = 4'd7;
    localparam logic [3:0] S_COPY_WR  = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    localparam int HW = sit_pkg::HANDLE_W;
    localparam int CW = sit_pkg::CW;

    logic [3:0]                  state_reg, state_next;
    logic [sit_pkg::SLOT_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [sit_pkg::SLOT_W-1:0]  idx_reg, idx_next;
    logic [sit_pkg::PROBE_W-1:0] probe_reg, probe_next;
    logic [sit_pkg::LEN_W-1:0]   pos_i_reg, pos_i_next;
    logic [sit_pkg::ENT_W-1:0]   entry_count_reg, entry_count_next;
    logic [HW:0]                 store_pos_reg, store_pos_next;
    logic [sit_pkg::HASH_W-1:0]  hash_reg, hash_next;
    logic [sit_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [HW-1:0]               cand_reg, cand_next;
    logic [HW-1:0]               base_reg, base_next;
    logic [HW-1:0]               res_handle_reg, res_handle_next;
    logic                        res_present_reg, res_present_next;
    logic [1:0]                  res_status_reg, res_status_next;

    sit_pkg::slot_t              slot_mem [sit_pkg::TABLE_SLOTS];
    sit_pkg::slot_t              slot_q;
    logic                        slot_we;
    logic [sit_pkg::SLOT_W-1:0]  slot_wa;
    sit_pkg::slot_t              slot_wd;

    logic [7:0]                  store_mem [sit_pkg::STORE_BYTES];
    logic [7:0]                  store_q;
    logic                        store_we;
    logic [HW-1:0]               store_wa;
    logic [7:0]                  store_wd;
    logic [HW:0]                 cmp_at;
    logic                        cmp_oob;
    logic                        is_end;
    logic [7:0]                  want;
    logic                        too_long;
    logic                        load_full;
    logic [CW-1:0]               need, in_blk, place_base, ext_pos;
    logic                        store_full;

    assign cmp_at   = {1'b0, cand_reg} + (HW + 1)'(pos_i_reg);
    assign cmp_oob  = (cmp_at >= (HW + 1)'(sit_pkg::STORE_BYTES));
    assign is_end   = (pos_i_reg == len_reg);
    assign want     = is_end ? 8'd0 : pend_q;
    assign too_long = desc.overlong || (CW'(desc.len) + 1 > CW'(sit_pkg::BLOCK_BYTES));
    assign load_full = ((CW'(entry_count_reg) << 2) > CW'(sit_pkg::TABLE_SLOTS * 3));
    assign need     = CW'(len_reg) + 1;
    assign ext_pos  = CW'(store_pos_reg);
    assign in_blk   = ext_pos & CW'(sit_pkg::BLOCK_BYTES - 1);
    assign place_base = (in_blk + need > CW'(sit_pkg::BLOCK_BYTES))
                        ? ext_pos - in_blk + CW'(sit_pkg::BLOCK_BYTES) : ext_pos;
    assign store_full = (place_base + need > CW'(sit_pkg::STORE_BYTES));

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        idx_next         = idx_reg;
        probe_next       = probe_reg;
        pos_i_next       = pos_i_reg;
        entry_count_next = entry_count_reg;
        store_pos_next   = store_pos_reg;
        hash_next        = hash_reg;
        len_next         = len_reg;
        cand_next        = cand_reg;
        base_next        = base_reg;
        res_handle_next  = res_handle_reg;
        res_present_next = res_present_reg;
        res_status_next  = res_status_reg;
        ctl.pop          = 1'b0;
        ctl.busy         = (state_reg != S_IDLE);
        ctl.pend_addr    = pos_i_reg[sit_pkg::PEND_AW-1:0];
        slot_we          = 1'b0;
        slot_wa          = idx_reg;
        slot_wd          = '0;
        store_we         = 1'b0;
        store_wa         = HW'(base_reg + HW'(pos_i_reg));
        store_wd         = want;
        unique case (state_reg)
            S_CLEAR:
            begin
                slot_we      = 1'b1;
                slot_wa      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == sit_pkg::SLOT_W'(sit_pkg::TABLE_SLOTS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (desc.valid)
                begin
                    ctl.pop          = 1'b1;
                    hash_next        = desc.hash;
                    len_next         = desc.len;
                    res_handle_next  = '0;
                    res_present_next = 1'b0;
                    res_status_next  = sit_pkg::ST_OK;
                    idx_next         = desc.hash[sit_pkg::SLOT_W-1:0];
                    probe_next       = '0;
                    if (too_long)
                    begin
                        res_status_next = sit_pkg::ST_TOO_LONG;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_SLOT_RD;
                end
            end
            S_SLOT_RD:
                state_next = S_SLOT_CHK;
            S_SLOT_CHK:
            begin
                if (!slot_q.valid)
                    state_next = S_PLACE;
                else if (slot_q.hash == hash_reg)
                begin
                    cand_next  = slot_q.handle;
                    pos_i_next = '0;
                    state_next = S_CMP_RD;
                end
                else if (probe_reg == sit_pkg::PROBE_W'(sit_pkg::TABLE_SLOTS - 1))
                begin
                    res_status_next = sit_pkg::ST_TABLE_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_SLOT_RD;
                end
            end
            S_CMP_RD:
                state_next = S_CMP_CHK;
            S_CMP_CHK:
            begin
                if (cmp_oob || (store_q != want))
                begin
                    // mismatch: advance to the next slot unless every slot has been probed
                    if (probe_reg == sit_pkg::PROBE_W'(sit_pkg::TABLE_SLOTS - 1))
                    begin
                        res_status_next = sit_pkg::ST_TABLE_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        probe_next = probe_reg + 1'b1;
                        state_next = S_SLOT_RD;
                    end
                end
                else if (is_end)
                begin
                    res_handle_next  = cand_reg;
                    res_present_next = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    pos_i_next = pos_i_reg + 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_PLACE:
            begin
                if (load_full)
                begin
                    res_status_next = sit_pkg::ST_TABLE_FULL;
                    state_next      = S_DONE;
                end
                else if (store_full)
                begin
                    res_status_next = sit_pkg::ST_STORE_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    base_next  = place_base[HW-1:0];
                    pos_i_next = '0;
                    state_next = S_COPY_RD;
                end
            end
            S_COPY_RD:
                state_next = S_COPY_WR;
            S_COPY_WR:
            begin
                store_we = 1'b1;
                if (is_end)
                begin
                    slot_we          = 1'b1;
                    slot_wd.valid    = 1'b1;
                    slot_wd.hash     = hash_reg;
                    slot_wd.handle   = base_reg;
                    entry_count_next = entry_count_reg + 1'b1;
                    store_pos_next   = (HW + 1)'(CW'(base_reg) + need);
                    res_handle_next  = base_reg;
                    state_next       = S_DONE;
                end
                else
                begin
                    pos_i_next = pos_i_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            idx_reg         <= '0;
            probe_reg       <= '0;
            pos_i_reg       <= '0;
            entry_count_reg <= '0;
            store_pos_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            idx_reg         <= idx_next;
            probe_reg       <= probe_next;
            pos_i_reg       <= pos_i_next;
            entry_count_reg <= entry_count_next;
            store_pos_reg   <= store_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg        <= hash_next;
        len_reg         <= len_next;
        cand_reg        <= cand_next;
        base_reg        <= base_next;
        res_handle_reg  <= res_handle_next;
        res_present_reg <= res_present_next;
        res_status_reg  <= res_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_q <= slot_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[store_wa] <= store_wd;
        store_q <= store_mem[cmp_at[HW-1:0]];
    end

    assign done        = (state_reg == S_DONE);
    assign handle      = res_handle_reg;
    assign was_present = res_present_reg;
    assign status      = res_status_reg;
    assign hash_value  = hash_reg;
    assign length      = len_reg;

    a_hit_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_present) |-> (status == sit_pkg::ST_OK))
        else $error("hit reported with a refusal status");

    a_refusal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != sit_pkg::ST_OK)) |-> (handle == '0 && !was_present))
        else $error("refusal carries a handle");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pop |=> (state_reg != S_IDLE))
        else $error("popped string was not taken up");

    a_entries_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(entry_count_reg) <= CW'(sit_pkg::TABLE_SLOTS))
        else $error("entry count beyond table size");

endmodule

`default_nettype wire

/* rtl/core/string_interning_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// string_interning_table
// FNV-1a string interner over a linearly probed slot table and byte store.
// ----------------------------------------------------------------------------
// A string arrives one byte per transaction (start while busy is low). After
// the transaction marked last, busy stays high while the string is looked
// up: the back end takes the string up, then reads and checks each probed
// slot, reads and checks each stored byte (length plus terminator) for every
// slot whose hash matches, and on insertion places the string and then
// reads and writes each copied byte (length plus terminator). A string that
// is too long skips the probing. The result is shown for exactly one cycle
// with done high, which is the last busy cycle, and cannot be held off.
// After reset busy stays high while every slot of the table is cleared.
// ----------------------------------------------------------------------------
module string_interning_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [7:0]                    char_byte,
    input  wire logic                          no_byte,
    input  wire logic                          last,
    output logic                               done,
    output logic [sit_pkg::HANDLE_W-1:0]       handle,
    output logic                               was_present,
    output logic [1:0]                         status,
    output logic [sit_pkg::HASH_W-1:0]         hash_value,
    output logic [sit_pkg::LEN_W-1:0]          length
);

    sit_pkg::bk_ctl_t  ctl;
    sit_pkg::fr_desc_t desc;
    logic [7:0]        pend_q;

    sit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .char_byte (char_byte),
        .no_byte   (no_byte),
        .last      (last),
        .ctl       (ctl),
        .desc      (desc),
        .pend_q    (pend_q)
    );

    sit_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .desc        (desc),
        .pend_q      (pend_q),
        .ctl         (ctl),
        .done        (done),
        .handle      (handle),
        .was_present (was_present),
        .status      (status),
        .hash_value  (hash_value),
        .length      (length)
    );

endmodule

`default_nettype wire

/* verif/string_interning_table_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// string_interning_table_test
// Self-checking bench for the string interning table.
// ----------------------------------------------------------------------------
// Strings are fed one byte per transaction with random gaps. A local copy of
// the slot table and byte store predicts each lookup result (hash, length,
// handle, hit flag, status). Results are compared in order as they appear.
// A directed run covers empty strings, zero and all-ones bytes, embedded zeros
// and strings closed by a byte-less item. A random run mixes new strings,
// repeats and overlong strings, and a short final phase repeats old strings.
// ----------------------------------------------------------------------------
module string_interning_table_test;

    typedef struct {
        logic [7:0] b;
        logic       nb;
        logic       lst;
        int         gap;
        bit         drain;
    } byte_item_t;

    typedef struct {
        logic [sit_pkg::HANDLE_W-1:0] handle;
        logic                         present;
        logic [1:0]                   status;
        logic [sit_pkg::HASH_W-1:0]   hash;
        logic [sit_pkg::LEN_W-1:0]    len;
    } lookup_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [7:0]                   char_byte = '0;
    logic                         no_byte = 1'b0;
    logic                         last = 1'b0;
    logic                         busy;
    logic                         done;
    logic [sit_pkg::HANDLE_W-1:0] handle;
    logic                         was_present;
    logic [1:0]                   status;
    logic [sit_pkg::HASH_W-1:0]   hash_value;
    logic [sit_pkg::LEN_W-1:0]    length;

    string_interning_table i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .char_byte   (char_byte),
        .no_byte     (no_byte),
        .last        (last),
        .done        (done),
        .handle      (handle),
        .was_present (was_present),
        .status      (status),
        .hash_value  (hash_value),
        .length      (length)
    );

    always #5 clk = ~clk;

    byte_item_t byte_q[$];
    lookup_t    lookup_q[$];
    int         errors = 0;
    int         item_count = 0;
    bit         burst = 1'b0;

    // history of sent strings, kept flat
    logic [7:0] hist_bytes[$];
    int         hist_at[$];
    int         hist_len[$];
    logic [7:0] str_buf[0:299];

    // predictor state
    logic [sit_pkg::HASH_W-1:0] run_hash = sit_pkg::HASH_BASIS;
    logic [7:0]                 pend[0:sit_pkg::MAX_LENGTH-1];
    int                         pend_len = 0;
    bit                         overlong = 1'b0;
    bit                         tbl_valid[0:sit_pkg::TABLE_SLOTS-1];
    logic [sit_pkg::HASH_W-1:0] tbl_hash[0:sit_pkg::TABLE_SLOTS-1];
    int                         tbl_handle[0:sit_pkg::TABLE_SLOTS-1];
    int                         entries = 0;
    logic [7:0]                 store[int];
    int                         store_pos = 0;

    int n_hits = 0, n_inserts = 0, n_too_long = 0, n_table_full = 0, n_store_full = 0;

    initial
    begin
        for (int i = 0; i < sit_pkg::TABLE_SLOTS; i++)
            tbl_valid[i] = 1'b0;
    end

    function automatic bit stored_matches(input int base, input int len);
        logic [7:0] want;
        logic [7:0] got;
        for (int i = 0; i <= len; i++)
        begin
            want = (i < len) ? pend[i] : 8'h00;
            if (base + i >= sit_pkg::STORE_BYTES)
                return 1'b0;
            got = store.exists(base + i) ? store[base + i] : 8'h00;
            if (got != want)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic intern_predict(input byte_item_t it);
        lookup_t r;
        int      idx;
        int      free_idx;
        bit      have_free;
        bit      hit;
        int      pos;
        int      in_block;
        if (!it.nb)
        begin
            run_hash = (run_hash ^ {24'd0, it.b}) * sit_pkg::HASH_PRIME;
            if (pend_len < sit_pkg::MAX_LENGTH)
            begin
                pend[pend_len] = it.b;
                pend_len++;
            end
            else
                overlong = 1'b1;
        end
        if (it.lst)
        begin
            r.handle = '0;
            r.present = 1'b0;
            r.status = sit_pkg::ST_OK;
            r.hash = run_hash;
            r.len = pend_len[sit_pkg::LEN_W-1:0];
            have_free = 1'b0;
            hit = 1'b0;
            free_idx = 0;
            if (overlong || pend_len + 1 > sit_pkg::BLOCK_BYTES)
                r.status = sit_pkg::ST_TOO_LONG;
            else
            begin
                idx = int'(run_hash & (sit_pkg::TABLE_SLOTS - 1));
                for (int p = 0; p < sit_pkg::TABLE_SLOTS; p++)
                begin
                    if (!tbl_valid[idx])
                    begin
                        have_free = 1'b1;
                        free_idx = idx;
                        break;
                    end
                    if (tbl_hash[idx] == run_hash && stored_matches(tbl_handle[idx], pend_len))
                    begin
                        hit = 1'b1;
                        r.handle = tbl_handle[idx][sit_pkg::HANDLE_W-1:0];
                        r.present = 1'b1;
                        break;
                    end
                    idx = (idx + 1) & (sit_pkg::TABLE_SLOTS - 1);
                end
                if (!hit)
                begin
                    if (entries * 4 > sit_pkg::TABLE_SLOTS * 3 || !have_free)
                        r.status = sit_pkg::ST_TABLE_FULL;
                    else
                    begin
                        pos = store_pos;
                        in_block = pos % sit_pkg::BLOCK_BYTES;
                        // move to the next block rather than straddle one
                        if (in_block + pend_len + 1 > sit_pkg::BLOCK_BYTES)
                            pos += sit_pkg::BLOCK_BYTES - in_block;
                        if (pos + pend_len + 1 > sit_pkg::STORE_BYTES)
                            r.status = sit_pkg::ST_STORE_FULL;
                        else
                        begin
                            for (int i = 0; i < pend_len; i++)
                                store[pos + i] = pend[i];
                            store[pos + pend_len] = 8'h00;
                            store_pos = pos + pend_len + 1;
                            tbl_valid[free_idx] = 1'b1;
                            tbl_hash[free_idx] = run_hash;
                            tbl_handle[free_idx] = pos;
                            entries++;
                            r.handle = pos[sit_pkg::HANDLE_W-1:0];
                        end
                    end
                end
            end
            lookup_q.push_back(r);
            run_hash = sit_pkg::HASH_BASIS;
            pend_len = 0;
            overlong = 1'b0;
        end
    endtask

    // driver
    byte_item_t cur;
    int         gap_left = 0;
    bit         armed = 1'b0;
    bit         go;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            go = 1'b0;
            if (start && !busy)
                intern_predict(cur);
            if (!start || !busy)
            begin
                if (byte_q.size() > 0)
                begin
                    if (!armed)
                    begin
                        gap_left = byte_q[0].gap;
                        armed = 1'b1;
                    end
                    if (gap_left > 0)
                        gap_left--;
                    else if (!(byte_q[0].drain && lookup_q.size() != 0))
                    begin
                        cur = byte_q.pop_front();
                        armed = 1'b0;
                        go = 1'b1;
                    end
                end
                start     <= go;
                char_byte <= cur.b;
                no_byte   <= cur.nb;
                last      <= cur.lst;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done)
        begin
            if (lookup_q.size() == 0)
            begin
                $error("result with nothing outstanding: hash 0x%0h", hash_value);
                errors++;
            end
            else
            begin
                e = lookup_q.pop_front();
                check_field("handle", 32'(e.handle), 32'(handle));
                check_field("was_present", 32'(e.present), 32'(was_present));
                check_field("status", 32'(e.status), 32'(status));
                check_field("hash_value", e.hash, hash_value);
                check_field("length", 32'(e.len), 32'(length));
            end
            if (status == sit_pkg::ST_TOO_LONG) n_too_long++;
            else if (status == sit_pkg::ST_TABLE_FULL) n_table_full++;
            else if (status == sit_pkg::ST_STORE_FULL) n_store_full++;
            else if (was_present) n_hits++;
            else n_inserts++;
        end
    end

    function automatic int draw_gap();
        if ($urandom_range(39) == 0)
            burst = ~burst;
        return burst ? 0 : int'($urandom_range(13));
    endfunction

    task automatic push_item(input logic [7:0] b, input logic nb, input logic lst,
                             input bit drain);
        byte_item_t it;
        it.b = b;
        it.nb = nb;
        it.lst = lst;
        it.gap = draw_gap();
        it.drain = drain;
        byte_q.push_back(it);
        item_count++;
    endtask

    // send str_buf[0:n-1]; close with a byte-less item when asked or when empty
    task automatic send_string(input int n, input bit nb_close, input bit drain);
        bit close_apart;
        close_apart = nb_close || (n == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) == 0)
                push_item(8'($urandom), 1'b1, 1'b0, 1'b0);
            push_item(str_buf[i], 1'b0, (i == n - 1) && !close_apart, drain && i == 0);
        end
        if (close_apart)
            push_item(8'($urandom), 1'b1, 1'b1, drain && n == 0);
        if (n <= 60)
        begin
            hist_at.push_back(hist_bytes.size());
            hist_len.push_back(n);
            for (int i = 0; i < n; i++)
                hist_bytes.push_back(str_buf[i]);
        end
    endtask

    task automatic random_string(input int n, input int alphabet);
        for (int i = 0; i < n; i++)
            case (alphabet)
                0:       str_buf[i] = 8'($urandom);
                1:       str_buf[i] = 8'($urandom_range(2));
                default: str_buf[i] = 8'($urandom_range(8'h7a, 8'h61));
            endcase
    endtask

    int pick;
    int k;
    int n_long;

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, embedded zeros, byte-less items
        send_string(0, 1'b0, 1'b0);
        str_buf[0] = 8'h00; send_string(1, 1'b0, 1'b0);
        str_buf[0] = 8'hff; send_string(1, 1'b0, 1'b0);
        str_buf[0] = 8'h00; str_buf[1] = 8'h00; send_string(2, 1'b0, 1'b0);
        str_buf[0] = 8'h00; str_buf[1] = 8'h00; send_string(2, 1'b1, 1'b0);
        str_buf[0] = 8'hff; send_string(1, 1'b1, 1'b0);
        send_string(0, 1'b0, 1'b0);
        str_buf[0] = 8'h61; str_buf[1] = 8'h00; str_buf[2] = 8'h62;
        send_string(3, 1'b0, 1'b0);
        str_buf[0] = 8'h61; str_buf[1] = 8'h00; send_string(2, 1'b0, 1'b0);
        str_buf[0] = 8'h55; str_buf[1] = 8'haa; send_string(2, 1'b0, 1'b1);

        // random: new strings, repeats, a few at or over the length limit
        n_long = 0;
        k = 0;
        while (item_count < 520)
        begin
            pick = $urandom_range(99);
            k++;
            if (pick < 40 && hist_len.size() > 0)
            begin
                pick = $urandom_range(hist_len.size() - 1);
                for (int i = 0; i < hist_len[pick]; i++)
                    str_buf[i] = hist_bytes[hist_at[pick] + i];
                send_string(hist_len[pick], $urandom_range(3) == 0, k == 50);
            end
            else if (pick < 96 || n_long >= 4)
            begin
                pick = (pick < 90) ? $urandom_range(12) : $urandom_range(60, 20);
                random_string(pick, $urandom_range(2));
                send_string(pick, $urandom_range(3) == 0, k == 50);
            end
            else
            begin
                pick = sit_pkg::MAX_LENGTH - 1 + n_long;
                n_long++;
                random_string(pick, 0);
                send_string(pick, $urandom_range(1), 1'b0);
            end
        end

        // finish with a few repeats of earlier strings
        for (int s = 0; s < 5; s++)
        begin
            pick = $urandom_range(hist_len.size() - 1);
            for (int i = 0; i < hist_len[pick]; i++)
                str_buf[i] = hist_bytes[hist_at[pick] + i];
            send_string(hist_len[pick], 1'b0, 1'b0);
        end

        while (byte_q.size() != 0 || start)
            @(posedge clk);
        while (lookup_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Strings checked: %0d inserted, %0d found again, %0d too long,",
                 n_inserts, n_hits, n_too_long);
        $display("%0d refused on a full table, %0d on a full store; %0d mismatches.",
                 n_table_full, n_store_full, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timed out with %0d results outstanding", lookup_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
